/* hw/rtl/accshk_pkg.sv */
// Shared types and constants for the accelerometer shock magnitude block.
// No dependencies; imported by every module under hw/rtl.
package accshk_pkg;

	localparam int unsigned LEAK_SHIFT_DEF = 3;
	localparam int unsigned NUM_AXES       = 3;
	localparam int unsigned RAW_W          = 16;
	localparam int unsigned MG_W           = 14;
	localparam int unsigned SHOCK_W        = 16;
	localparam int unsigned SUM_W          = 30;  // 3 * 16380^2 stays below 2^30
	localparam int unsigned ROOT_W         = 31;
	localparam int unsigned IDX_W          = 4;
	localparam int unsigned IN_TDATA_W     = 48;
	localparam int unsigned OUT_TDATA_W    = 64;

	localparam logic [IDX_W-1:0]  SQ_LAST    = 4'd2;   // three axes, one square each
	localparam logic [IDX_W-1:0]  ROOT_LAST  = 4'd15;  // sixteen root digits
	localparam logic [ROOT_W-1:0] ROOT_BIT0  = 31'h4000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_SQ,
		ST_ROOT,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic             load;      // capture input beat
		logic             bias;      // update biases, form deviations
		logic             sq;        // square one axis, accumulate
		logic             sq_first;  // restart accumulator and root
		logic             root;      // one root digit
		logic [IDX_W-1:0] idx;       // axis or root digit index
		logic             out_load;  // move result into output register
	} cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or draining this cycle
	} sts_t;

endpackage

/* hw/rtl/accel_shock_magnitude.sv */
// Top level of the accelerometer shock magnitude block.
// Depends on accshk_pkg, accshk_ctrl and accshk_dp.
//
// Slave channel: one beat per sample, s_tdata = raw_x, raw_y, raw_z words of
// 16 bits each (12-bit count left-justified, low nibble ignored).
// Master channel: one beat per sample with x/y/z in milli-g and the shock
// magnitude, the floor root of the summed squared deviations from a leaky
// per-axis bias.
// From the accepted input beat to m_tvalid the sequencer walks the bias
// update, the three axis squares through the single shared 14x14 squarer,
// the sixteen digits of the digit-by-digit root and the output load. One
// sample is in flight at a time; s_tready is high only while the sequencer
// is idle, so no new sample is taken until the last result has been loaded.
// A finished result sits in the output register while the next sample is
// accepted and processed; the sequencer holds in its final step only if that
// register is still full and not draining when the next result is ready.
// Reset clears the biases and the primed flag: the first sample after reset
// loads the biases and reports a shock of zero. A stalled receiver holds
// m_tvalid and m_tdata steady until m_tready.
module accel_shock_magnitude
	import accshk_pkg::*;
#(
	parameter int unsigned LEAK_SHIFT = LEAK_SHIFT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // x_mg[13:0], y_mg[27:14], z_mg[41:28],
	                                          // shock_mag[57:42], zeros above
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer: walk load, bias, square, root and output steps.
	accshk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: hold sample, bias state, accumulator, root and output register.
	accshk_dp #(
		.LEAK_SHIFT (LEAK_SHIFT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// An accepted beat makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a sample was in flight");

	// A result only enters the output register when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten before it was taken");

	// A new output beat appears only after the sequencer loaded one.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("output valid rose without a result load");

	// No two datapath commands (load, bias, square, root, output load) overlap.
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.bias, cmd.sq, cmd.root, cmd.out_load}))
		else $error("datapath commands overlap");

endmodule

/* hw/rtl/accshk_ctrl.sv */
// Sequencer for the shock magnitude block: issues datapath commands per step.
// Depends on accshk_pkg.
module accshk_ctrl
	import accshk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t              state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.idx  = cnt_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_BIAS;
				end
			end
			ST_BIAS: begin
				cmd.bias = 1'b1;
				cnt_d    = '0;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq       = 1'b1;
				cmd.sq_first = (cnt_q == '0);
				if (cnt_q == SQ_LAST) begin
					cnt_d   = '0;
					state_d = ST_ROOT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT: begin
				cmd.root = 1'b1;
				if (cnt_q == ROOT_LAST) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/accshk_dp.sv */
// Datapath for the shock magnitude block: scaling, leaky bias, shared squarer,
// digit-by-digit square root and the output register. Depends on accshk_pkg.
module accshk_dp
	import accshk_pkg::*;
#(
	parameter int unsigned LEAK_SHIFT = LEAK_SHIFT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [MG_W-1:0]   mg_q   [NUM_AXES];
	logic [MG_W-1:0]   bias_q [NUM_AXES];
	logic [MG_W-1:0]   dmag_q [NUM_AXES];
	logic [MG_W-1:0]   bias_d [NUM_AXES];
	logic [MG_W-1:0]   dev_d  [NUM_AXES];
	logic              primed_q;
	logic [SUM_W-1:0]  v_q;
	logic [ROOT_W-1:0] root_q;
	logic              ovalid_q;
	logic [OUT_TDATA_W-1:0] out_q;

	// Leak each bias toward its reading, truncating the step toward zero.
	always_comb begin
		logic [MG_W:0] diff, dmag, stepm, bnew, dev;
		for (int a = 0; a < NUM_AXES; a++) begin
			diff  = {mg_q[a][MG_W-1], mg_q[a]} - {bias_q[a][MG_W-1], bias_q[a]};
			dmag  = diff[MG_W] ? (~diff + 1'b1) : diff;
			stepm = dmag >> LEAK_SHIFT;
			bnew  = diff[MG_W] ? ({bias_q[a][MG_W-1], bias_q[a]} - stepm)
			                   : ({bias_q[a][MG_W-1], bias_q[a]} + stepm);
			dev   = {mg_q[a][MG_W-1], mg_q[a]} - bnew;
			bias_d[a] = bnew[MG_W-1:0];
			dev_d[a]  = dev[MG_W] ? MG_W'(~dev + 1'b1) : dev[MG_W-1:0];
		end
	end

	logic [MG_W-1:0]   sq_in;
	logic [2*MG_W-1:0] sq_prod;

	always_comb begin
		unique case (cmd.idx)
			4'd0:    sq_in = dmag_q[0];
			4'd1:    sq_in = dmag_q[1];
			4'd2:    sq_in = dmag_q[2];
			default: sq_in = '0;
		endcase
		sq_prod = sq_in * sq_in;
	end

	logic [ROOT_W-1:0] rbit;
	logic [ROOT_W:0]   trial;
	logic              take;

	always_comb begin
		rbit  = ROOT_BIT0 >> {cmd.idx, 1'b0};
		trial = {1'b0, root_q} + {1'b0, rbit};
		take  = ({{(ROOT_W + 1 - SUM_W){1'b0}}, v_q} >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				bias_q[a] <= '0;
			end
		end else if (cmd.bias) begin
			primed_q <= 1'b1;
			for (int a = 0; a < NUM_AXES; a++) begin
				bias_q[a] <= primed_q ? bias_d[a] : mg_q[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				mg_q[a] <= {s_tdata[a*RAW_W + 4 +: 12], 2'b00};
			end
		end
		if (cmd.bias) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				dmag_q[a] <= primed_q ? dev_d[a] : '0;
			end
		end
		if (cmd.sq) begin
			v_q <= cmd.sq_first ? SUM_W'(sq_prod) : v_q + SUM_W'(sq_prod);
			if (cmd.sq_first) begin
				root_q <= '0;
			end
		end else if (cmd.root) begin
			if (take) begin
				v_q    <= v_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + rbit;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.out_load) begin
			// root of a value below 2^30 fits in 15 bits, so no clamp is needed
			out_q <= {{(OUT_TDATA_W - 3*MG_W - SHOCK_W){1'b0}}, root_q[SHOCK_W-1:0],
			          mg_q[2], mg_q[1], mg_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign sts.out_free = !ovalid_q || m_tready;
	assign m_tvalid     = ovalid_q;
	assign m_tdata      = out_q;

endmodule
